// ===== hdl/mexp_pkg.sv =====
// Shared types for the modular exponentiation core: controller states and the control bundles.
package mexp_pkg;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_REDUCE  = 7'b0000010,
      ST_SQ_TAKE = 7'b0000100,
      ST_LOAD    = 7'b0001000,
      ST_MUL     = 7'b0010000,
      ST_COMMIT  = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // take base and exponent, start base reduction
      logic step;       // one bit step of both modular multipliers
      logic sq_take;    // reduced base becomes the running square
      logic load_pair;  // load both multipliers for one exponent bit
      logic commit;     // write back product (if the exponent bit is set) and square, shift exponent
      logic finish;     // register the final residue
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exp_rest_zero;  // no set exponent bit above the current one
   } status_type;

endpackage

// ===== hdl/modular_exponentiation_core.sv =====
// Top level of the modular exponentiation core: controller plus datapath.
//
// Computes req_base to the power req_exponent modulo the modulus register by right-to-left
// square-and-multiply. A transaction is taken when start is high and busy is low. The base
// is first reduced; then each exponent bit, from bit 0 up to the highest set bit (at least
// bit 0), costs one pass of two bit-serial modular multipliers working side by side (the
// product into the accumulator and the square). The result appears on rsp_power_mod for
// exactly one cycle with rsp_valid, in the cycle in which busy falls; the receiver cannot
// stall it. A modulus below 2 gives a result of 0. The modulus must be written through
// csr_wr_en / csr_wr_data only while no transaction is running; the block itself does not
// enforce this. It resets to 2.
module modular_exponentiation_core
   import mexp_pkg::*;
#(
   parameter int MOD_BITS = 20,
   parameter int EXP_BITS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MOD_BITS-1:0] req_base,
   input  logic [EXP_BITS-1:0] req_exponent,
   output logic                rsp_valid,
   output logic [MOD_BITS-1:0] rsp_power_mod,
   input  logic                csr_wr_en,
   input  logic [MOD_BITS-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   mexp_ctrl #(.MOD_BITS(MOD_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   mexp_datapath #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_base      (req_base),
      .req_exponent  (req_exponent),
      .rsp_power_mod (rsp_power_mod)
   );

endmodule

// ===== hdl/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: one multiplier bit per step, MSB first.
module mexp_mulmod
   import mexp_pkg::*;
#(
   parameter int W = 20
) (
   input  logic         clock,
   input  logic         load,
   input  logic         step,
   input  logic [W-1:0] x_in,
   input  logic [W-1:0] y_in,
   input  logic [W-1:0] modulus,
   output logic [W-1:0] result
);

   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] x_ff, x_in_q;
   logic [W-1:0] y_ff, y_in_q;
   logic [W:0]   dbl, red1, sum, red2, mod_ext;

   // The partial product stays below the modulus, so doubling and adding x stays below 2m
   // and a single conditional subtract after each keeps it reduced.
   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl     = {r_ff, 1'b0};
      red1    = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = red1 + (y_ff[W-1] ? {1'b0, x_ff} : '0);
      red2    = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   always_comb begin
      r_in   = r_ff;
      x_in_q = x_ff;
      y_in_q = y_ff;
      if (load) begin
         r_in   = '0;
         x_in_q = x_in;
         y_in_q = y_in;
      end else if (step) begin
         r_in   = red2[W-1:0];
         y_in_q = {y_ff[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      x_ff <= x_in_q;
      y_ff <= y_in_q;
   end

   assign result = r_ff;

endmodule

// ===== hdl/mexp_datapath.sv =====
// Datapath: modulus register, operand registers, exponent shifter and two modular multipliers.
module mexp_datapath
   import mexp_pkg::*;
#(
   parameter int MOD_BITS = 20,
   parameter int EXP_BITS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                csr_wr_en,
   input  logic [MOD_BITS-1:0] csr_wr_data,
   input  logic [MOD_BITS-1:0] req_base,
   input  logic [EXP_BITS-1:0] req_exponent,
   output logic [MOD_BITS-1:0] rsp_power_mod
);

   logic [MOD_BITS-1:0] modulus_ff, modulus_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] sq_ff, sq_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] result_ff, result_in;
   logic [MOD_BITS-1:0] prod_acc, prod_sq;
   logic [MOD_BITS-1:0] sq_x, sq_y;
   logic                sq_load;
   logic                mod_small;

   // Reducing the base is a multiply by one with the raw base as multiplier bits.
   assign sq_x    = cmd.capture ? MOD_BITS'(1) : sq_ff;
   assign sq_y    = cmd.capture ? req_base : sq_ff;
   assign sq_load = cmd.capture | cmd.load_pair;

   mexp_mulmod #(.W(MOD_BITS)) u_mul_acc (
      .clock   (clock),
      .load    (cmd.load_pair),
      .step    (cmd.step),
      .x_in    (acc_ff),
      .y_in    (sq_ff),
      .modulus (modulus_ff),
      .result  (prod_acc)
   );

   mexp_mulmod #(.W(MOD_BITS)) u_mul_sq (
      .clock   (clock),
      .load    (sq_load),
      .step    (cmd.step),
      .x_in    (sq_x),
      .y_in    (sq_y),
      .modulus (modulus_ff),
      .result  (prod_sq)
   );

   // A modulus of zero or one has no meaningful residue; the result is forced to zero.
   assign mod_small = (modulus_ff[MOD_BITS-1:1] == '0);

   always_comb begin
      modulus_in = csr_wr_en ? csr_wr_data : modulus_ff;
      acc_in     = acc_ff;
      sq_in      = sq_ff;
      exp_in     = exp_ff;
      result_in  = result_ff;
      if (cmd.capture) begin
         acc_in = MOD_BITS'(1);
         exp_in = req_exponent;
      end
      if (cmd.sq_take) begin
         sq_in = prod_sq;
      end
      if (cmd.commit) begin
         if (exp_ff[0]) begin
            acc_in = prod_acc;
         end
         sq_in  = prod_sq;
         exp_in = {1'b0, exp_ff[EXP_BITS-1:1]};
      end
      if (cmd.finish) begin
         result_in = mod_small ? '0 : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_BITS'(2);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      exp_ff    <= exp_in;
      result_ff <= result_in;
   end

   assign status.exp_rest_zero = (exp_ff[EXP_BITS-1:1] == '0);
   assign rsp_power_mod        = result_ff;

endmodule

// ===== hdl/mexp_ctrl.sv =====
// Controller: sequences base reduction, one multiply pass per exponent bit, and the result strobe.
module mexp_ctrl
   import mexp_pkg::*;
#(
   parameter int MOD_BITS = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int CW = $clog2(MOD_BITS);
   localparam logic [CW-1:0] LAST_STEP = CW'(MOD_BITS - 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.step = 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = ST_SQ_TAKE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SQ_TAKE: begin
            cmd.sq_take = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_pair = 1'b1;
            cnt_in        = '0;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.step = 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = ST_COMMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.exp_rest_zero ? ST_FINISH : ST_LOAD;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ===== hdl/mexp_checker.sv =====
// Port-level checker for the modular exponentiation core, bound to the top level.
module mexp_checker
   import mexp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // An accepted transaction keeps the core busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting a transaction");

   // The result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A result only appears as the core finishes a transaction.
   a_strobe_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $fell(busy))
      else $error("result strobe without the end of a transaction");

   // Every finished transaction delivers its result.
   a_end_has_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("transaction ended without a result");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// ===== test/tb_modular_exponentiation_core.sv =====
// Self-checking testbench for the modular exponentiation core with a residue scoreboard.
module tb_modular_exponentiation_core;

   localparam int MOD_W = 20;
   localparam int EXP_W = 40;
   localparam int STALL_LIMIT = 6000;
   localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};
   localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [MOD_W-1:0] req_base = '0;
   logic [EXP_W-1:0] req_exponent = '0;
   logic             rsp_valid;
   logic [MOD_W-1:0] rsp_power_mod;
   logic             csr_wr_en = 1'b0;
   logic [MOD_W-1:0] csr_wr_data = '0;

   typedef struct {
      logic [MOD_W-1:0] base;
      logic [EXP_W-1:0] exponent;
      logic [MOD_W-1:0] modulus;
      logic [MOD_W-1:0] residue;
   } pending_power_type;

   class residue_board;
      pending_power_type pending[$];
      logic [MOD_W-1:0] modulus = MOD_W'(2);
      int mismatches = 0;

      function void set_modulus(logic [MOD_W-1:0] value);
         modulus = value;
      endfunction

      // Right-to-left square-and-multiply over every exponent bit.
      function logic [MOD_W-1:0] power_mod(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e);
         logic [63:0] acc;
         logic [63:0] sq;
         logic [63:0] m;
         m = 64'(modulus);
         if (m < 2) return '0;
         acc = 64'd1;
         sq = 64'(b) % m;
         for (int i = 0; i < EXP_W; i++) begin
            if (e[i]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
         end
         return acc[MOD_W-1:0];
      endfunction

      function void note_request(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e);
         pending_power_type item;
         item.base = b;
         item.exponent = e;
         item.modulus = modulus;
         item.residue = power_mod(b, e);
         pending.push_back(item);
      endfunction

      function void check_residue(logic [MOD_W-1:0] actual);
         pending_power_type item;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result %h with no transaction outstanding", actual);
            return;
         end
         item = pending.pop_front();
         if (actual !== item.residue) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Residue mismatch: base %h exponent %h modulus %h expected %h got %h",
                        item.base, item.exponent, item.modulus, item.residue, actual);
         end
      endfunction

      function bit passed();
         return mismatches == 0 && pending.size() == 0;
      endfunction
   endclass

   residue_board board;
   bit quiet = 1'b0;
   int stall_cycles = 0;

   modular_exponentiation_core uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_base      (req_base),
      .req_exponent  (req_exponent),
      .rsp_valid     (rsp_valid),
      .rsp_power_mod (rsp_power_mod),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_residue(rsp_power_mod);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Start stays high from one transaction to the next unless a pause or a modulus write drops it.
   task automatic send_request(input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e);
      start <= 1'b1;
      req_base <= b;
      req_exponent <= e;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(b, e);
   endtask

   task automatic sender_pause();
      int n;
      if (!quiet && $urandom_range(0, 99) < 17) begin
         start <= 1'b0;
         n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 1000);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [MOD_W-1:0] value);
      start <= 1'b0;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_modulus(value);
   endtask

   // Field extremes, exponent zero, bases at and above the modulus, single high bits.
   task automatic run_directed();
      logic [MOD_W-1:0] m;
      m = board.modulus;
      send_request('0, '0);                             sender_pause();
      send_request('0, 40'd5);                          sender_pause();
      send_request(MOD_MAX, '0);                        sender_pause();
      send_request(MOD_MAX, EXP_MAX);                   sender_pause();
      send_request(20'd1, EXP_MAX);                     sender_pause();
      send_request(m, 40'd3);                           sender_pause();
      send_request(m + 1'b1, 40'd65537);                sender_pause();
      send_request(m - 1'b1, 40'd2);                    sender_pause();
      send_request(MOD_W'($urandom), 40'h80_0000_0000); sender_pause();
      send_request(20'd2, 40'h55_5555_5555);            sender_pause();
      send_request(MOD_MAX - 1'b1, 40'hAA_AAAA_AAAA);   sender_pause();
      send_request(20'd3, 40'd1);                       sender_pause();
   endtask

   initial begin
      logic [MOD_W-1:0] m;
      logic [MOD_W-1:0] b;
      logic [EXP_W-1:0] e;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      write_modulus(MOD_MAX);
      run_directed();

      for (int p = 0; p < 9; p++) begin
         case (p)
            0: m = MOD_MAX;
            1: m = '0;
            2: m = 20'd1;
            3: m = 20'd3;
            4: m = 20'd3233;
            5: m = MOD_W'($urandom_range(2, 1048575));
            6: m = MOD_W'($urandom_range(2, 255));
            7: m = 20'd2;
            default: m = 20'h80000 | MOD_W'($urandom);
         endcase
         write_modulus(m);
         quiet = (p == 4);
         repeat (39) begin
            case ($urandom_range(0, 3))
               0, 1: b = MOD_W'($urandom);
               2: b = (m != 0) ? MOD_W'($urandom % m) : MOD_W'($urandom);
               default: begin
                  case ($urandom_range(0, 4))
                     0: b = '0;
                     1: b = 20'd1;
                     2: b = m - 1'b1;
                     3: b = m;
                     default: b = m + 1'b1;
                  endcase
               end
            endcase
            case ($urandom_range(0, 3))
               0, 1: e = EXP_W'({$urandom, $urandom});
               2: e = EXP_W'($urandom_range(0, 70000));
               default: e = EXP_W'({$urandom, $urandom}) >> $urandom_range(0, EXP_W - 1);
            endcase
            send_request(b, e);
            sender_pause();
         end
      end

      start <= 1'b0;
      wait_drained();
      repeat (30) @(posedge clock);
      if (board.passed()) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
